>>> hw/rtl/cdo_pkg.sv
package cdo_pkg;

    // default width of the day count that is honored
    localparam int CDO_OFFSET_BITS = 16;

    localparam logic [13:0] CDO_YEAR_MAX = 14'd9999;

    // direction of the move
    localparam logic CDO_MODE_ADD = 1'b0;
    localparam logic CDO_MODE_SUB = 1'b1;

    // status codes
    localparam logic [1:0] CDO_ST_OK  = 2'd0;
    localparam logic [1:0] CDO_ST_BAD = 2'd1;
    localparam logic [1:0] CDO_ST_SAT = 2'd2;

    // reciprocal of 100 for year / 100, exact for years below 16384
    localparam logic [12:0] CDO_RECIP_100 = 13'd5243;
    localparam int          CDO_RECIP_SH  = 19;

    typedef struct packed {
        logic        mode;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [15:0] offset_days;
    } t_cdo_in;

    typedef struct packed {
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [1:0]  status;
    } t_cdo_out;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_REM  = 6'b000100,
        S_CHK  = 6'b001000,
        S_FWD  = 6'b010000,
        S_BWD  = 6'b100000
    } t_cdo_state;

    // month length table, out-of-range months read as 31
    function automatic logic [4:0] cdo_month_len(logic [3:0] m, logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/cdo_mlen.sv
module cdo_mlen
    import cdo_pkg::*;
(
    input  logic [3:0] i_month,
    input  logic [6:0] i_yl,
    input  logic [1:0] i_cl,
    output logic [4:0] o_len
);

    logic leap;

    // leap year from year mod 100 and century mod 4
    assign leap = (i_yl != 7'd0) ? (i_yl[1:0] == 2'd0) : (i_cl == 2'd0);

    assign o_len = cdo_month_len(i_month, leap);

endmodule

>>> hw/rtl/cdo_day_alu.sv
module cdo_day_alu
    import cdo_pkg::*;
#(
    parameter int W = CDO_OFFSET_BITS + 2
) (
    input  logic signed [W-1:0] i_a,
    input  logic        [W-1:0] i_b,
    input  logic                i_sub,
    output logic signed [W-1:0] o_sum,
    output logic                o_pos
);

    // shared add / subtract of the day accumulator
    assign o_sum = i_sub ? (i_a - $signed(i_b)) : (i_a + $signed(i_b));

    // result strictly above zero
    assign o_pos = !o_sum[W-1] && (o_sum != '0);

endmodule

>>> hw/rtl/calendar_day_offset_core.sv
// channel  | ports                   | handshake
// ---------+-------------------------+------------------------------
// command  | i_in (t_cdo_in)         | beat taken when start & !busy
// result   | o_out (t_cdo_out)       | o_valid high for one cycle
//
// After a command is accepted, three setup states run (year / 100, year mod
// 100, date check), then one step per month crossed through the shared
// month-length table and day adder, plus a final step for the result strobe.
// Synchronous active-low reset returns the sequencer to idle.
// The result is shown for one cycle only; the receiver cannot stall.
module calendar_day_offset_core
    import cdo_pkg::*;
#(
    parameter int OFFSET_BITS = CDO_OFFSET_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cdo_in  i_in,
    output logic     o_valid,
    output t_cdo_out o_out
);

    localparam int W = OFFSET_BITS + 2;
    localparam logic [W-1:0] OFF_MASK = {2'b00, {OFFSET_BITS{1'b1}}};

    t_cdo_state r_state, n_state;

    logic               [13:0] r_year, n_year;
    logic               [3:0]  r_month, n_month;
    logic               [4:0]  r_day;
    logic                      r_mode;
    logic               [W-1:0] r_off;
    logic               [7:0]  r_q;
    logic               [6:0]  r_yl, n_yl;
    logic               [1:0]  r_cl, n_cl;
    logic signed        [W-1:0] r_acc, n_acc;
    logic                      r_valid, n_valid;
    t_cdo_out                  r_out, n_out;

    logic [26:0] q_prod;
    logic [14:0] q100;
    logic [13:0] rem_full;

    logic [3:0]  prev_month;
    logic [6:0]  prev_yl;
    logic [1:0]  prev_cl;
    logic [3:0]  ml_month;
    logic [6:0]  ml_yl;
    logic [1:0]  ml_cl;
    logic [4:0]  ml_len;

    logic signed [W-1:0] alu_a;
    logic        [W-1:0] alu_b;
    logic                alu_sub;
    logic signed [W-1:0] alu_sum;
    logic                alu_pos;

    logic date_bad;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // year / 100 by reciprocal, then remainder
    assign q_prod   = r_year * CDO_RECIP_100;
    assign q100     = r_q * 7'd100;
    assign rem_full = r_year - q100[13:0];

    // previous month and its year position, for stepping back
    always_comb begin
        if (r_month == 4'd1) begin
            prev_month = 4'd12;
            prev_yl    = (r_yl == 7'd0) ? 7'd99 : (r_yl - 7'd1);
            prev_cl    = (r_yl == 7'd0) ? (r_cl - 2'd1) : r_cl;
        end else begin
            prev_month = r_month - 4'd1;
            prev_yl    = r_yl;
            prev_cl    = r_cl;
        end
    end

    // month-length lookup input select
    always_comb begin
        if (r_state == S_BWD) begin
            ml_month = prev_month;
            ml_yl    = prev_yl;
            ml_cl    = prev_cl;
        end else begin
            ml_month = r_month;
            ml_yl    = r_yl;
            ml_cl    = r_cl;
        end
    end

    cdo_mlen u_mlen (
        .i_month (ml_month),
        .i_yl    (ml_yl),
        .i_cl    (ml_cl),
        .o_len   (ml_len)
    );

    // shared adder operand select
    always_comb begin
        if (r_state == S_CHK) begin
            alu_a   = $signed(W'(r_day));
            alu_b   = r_off;
            alu_sub = (r_mode == CDO_MODE_SUB);
        end else begin
            alu_a   = r_acc;
            alu_b   = W'(ml_len);
            alu_sub = (r_state == S_FWD);
        end
    end

    cdo_day_alu #(
        .W (W)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum),
        .o_pos (alu_pos)
    );

    assign date_bad = (r_year > CDO_YEAR_MAX) || (r_month == 4'd0) || (r_month > 4'd12) ||
                      (r_day == 5'd0) || (r_day > ml_len);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_year  = r_year;
        n_month = r_month;
        n_yl    = r_yl;
        n_cl    = r_cl;
        n_acc   = r_acc;
        n_valid = 1'b0;
        n_out   = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_year  = i_in.year_in;
                    n_month = i_in.month_in;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_state = S_REM;
            end
            S_REM: begin
                n_yl    = rem_full[6:0];
                n_cl    = r_q[1:0];
                n_state = S_CHK;
            end
            S_CHK: begin
                if (date_bad) begin
                    n_out   = '{year_out: 14'd0, month_out: 4'd1, day_out: 5'd1,
                                status: CDO_ST_BAD};
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_acc   = alu_sum;
                    n_state = (r_mode == CDO_MODE_SUB) ? S_BWD : S_FWD;
                end
            end
            S_FWD: begin
                if (alu_pos) begin
                    if (r_month == 4'd12) begin
                        if (r_year == CDO_YEAR_MAX) begin
                            n_out   = '{year_out: CDO_YEAR_MAX, month_out: 4'd12,
                                        day_out: 5'd31, status: CDO_ST_SAT};
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_acc   = alu_sum;
                            n_month = 4'd1;
                            n_year  = r_year + 14'd1;
                            n_yl    = (r_yl == 7'd99) ? 7'd0 : (r_yl + 7'd1);
                            n_cl    = (r_yl == 7'd99) ? (r_cl + 2'd1) : r_cl;
                        end
                    end else begin
                        n_acc   = alu_sum;
                        n_month = r_month + 4'd1;
                    end
                end else begin
                    n_out   = '{year_out: r_year, month_out: r_month,
                                day_out: r_acc[4:0], status: CDO_ST_OK};
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BWD: begin
                if (r_acc[W-1] || (r_acc == '0)) begin
                    if ((r_month == 4'd1) && (r_year == 14'd0)) begin
                        n_out   = '{year_out: 14'd0, month_out: 4'd1, day_out: 5'd1,
                                    status: CDO_ST_SAT};
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_acc   = alu_sum;
                        n_month = prev_month;
                        n_yl    = prev_yl;
                        n_cl    = prev_cl;
                        n_year  = (r_month == 4'd1) ? (r_year - 14'd1) : r_year;
                    end
                end else begin
                    n_out   = '{year_out: r_year, month_out: r_month,
                                day_out: r_acc[4:0], status: CDO_ST_OK};
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_year  <= n_year;
        r_month <= n_month;
        r_yl    <= n_yl;
        r_cl    <= n_cl;
        r_acc   <= n_acc;
        r_out   <= n_out;
        if ((r_state == S_IDLE) && start) begin
            r_day  <= i_in.day_in;
            r_mode <= i_in.mode;
            r_off  <= W'(i_in.offset_days) & OFF_MASK;
        end
        if (r_state == S_DIV) begin
            r_q <= q_prod[CDO_RECIP_SH +: 8];
        end
    end

endmodule

>>> bench/calendar_day_offset_checker.sv
module calendar_day_offset_checker
    import cdo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     busy,
    input  logic     o_valid,
    input  t_cdo_in  in_beat,
    input  t_cdo_out out_beat,
    output int       fail_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // dates that the block still owes, oldest first
    t_cdo_out expected_dates[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // gregorian month length, year 0 is a leap year
    function automatic int days_in_month(input int yr, input int mon);
        bit leap;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        if (mon == 2)
            return leap ? 29 : 28;
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
            return 30;
        return 31;
    endfunction

    // move the date by the day count, one month per step
    function automatic t_cdo_out shift_date(input t_cdo_in cmd);
        int         yr;
        int         mon;
        int         dd;
        int         span;
        logic [1:0] st;
        t_cdo_out   res;
        yr   = int'(cmd.year_in);
        mon  = int'(cmd.month_in);
        dd   = int'(cmd.day_in);
        span = int'({16'd0, cmd.offset_days} & ((32'd1 << CDO_OFFSET_BITS) - 32'd1));
        st   = CDO_ST_OK;
        if (yr > int'(CDO_YEAR_MAX) || mon < 1 || mon > 12 || dd < 1 ||
            dd > days_in_month(yr, mon)) begin
            yr  = 0;
            mon = 1;
            dd  = 1;
            st  = CDO_ST_BAD;
        end else if (cmd.mode != CDO_MODE_SUB) begin
            dd += span;
            while (dd > days_in_month(yr, mon)) begin
                dd -= days_in_month(yr, mon);
                mon++;
                if (mon > 12) begin
                    mon = 1;
                    yr++;
                    // ran past the last day of the last year
                    if (yr > int'(CDO_YEAR_MAX)) begin
                        yr  = int'(CDO_YEAR_MAX);
                        mon = 12;
                        dd  = 31;
                        st  = CDO_ST_SAT;
                        break;
                    end
                end
            end
        end else begin
            dd -= span;
            while (dd < 1) begin
                mon--;
                // wrap to december before reading its length
                if (mon < 1) begin
                    mon = 12;
                    yr--;
                    if (yr < 0) begin
                        yr  = 0;
                        mon = 1;
                        dd  = 1;
                        st  = CDO_ST_SAT;
                        break;
                    end
                end
                dd += days_in_month(yr, mon);
            end
        end
        res.year_out  = yr[13:0];
        res.month_out = mon[3:0];
        res.day_out   = dd[4:0];
        res.status    = st;
        return res;
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: date result mismatch on %s: got %0d, expected %0d",
                 $time, field, got, want);
        fail_count++;
    endtask

    // sample both channels at the edge that accepts a beat
    always @(posedge i_clk) begin
        t_cdo_out want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = expected_dates.pop_front();
                    if (out_beat.year_out !== want.year_out)
                        report_mismatch("year_out", out_beat.year_out, want.year_out);
                    if (out_beat.month_out !== want.month_out)
                        report_mismatch("month_out", out_beat.month_out, want.month_out);
                    if (out_beat.day_out !== want.day_out)
                        report_mismatch("day_out", out_beat.day_out, want.day_out);
                    if (out_beat.status !== want.status)
                        report_mismatch("status", out_beat.status, want.status);
                end
            end
            if (start && !busy)
                expected_dates.push_back(shift_date(in_beat));
        end
        pending <= expected_dates.size();
    end

endmodule

>>> bench/calendar_day_offset_core_test.sv
module calendar_day_offset_core_test
    import cdo_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   PHASE_ITEMS    = 62;
    localparam int   WATCHDOG_LIMIT = 12000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    logic     o_valid;
    t_cdo_in  i_in;
    t_cdo_out o_out;
    int       fail_count;
    int       pending;
    int       idle_cycles = 0;

    calendar_day_offset_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    calendar_day_offset_checker date_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .o_valid    (o_valid),
        .in_beat    (i_in),
        .out_beat   (o_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // give up when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_cdo_in date_cmd(input logic mode, input int yr, input int mon,
                                         input int dd, input int span);
        t_cdo_in cmd;
        cmd.mode        = mode;
        cmd.year_in     = yr[13:0];
        cmd.month_in    = mon[3:0];
        cmd.day_in      = dd[4:0];
        cmd.offset_days = span[15:0];
        return cmd;
    endfunction

    // mostly valid dates, some near the year limits, short offsets weighted heavily
    function automatic t_cdo_in random_cmd();
        int yr;
        int mon;
        int dd;
        int span;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)      yr = $urandom_range(0, 30);
        else if (pick < 24) yr = $urandom_range(9970, 9999);
        else if (pick < 32) yr = $urandom_range(0, 16383);
        else                yr = $urandom_range(0, 9999);
        mon = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        pick = $urandom_range(0, 99);
        if (pick < 75)      dd = $urandom_range(1, 28);
        else if (pick < 95) dd = $urandom_range(29, 31);
        else                dd = $urandom_range(0, 31);
        pick = $urandom_range(0, 99);
        if (pick < 40)      span = $urandom_range(0, 60);
        else if (pick < 75) span = $urandom_range(0, 1500);
        else if (pick < 92) span = $urandom_range(0, 20000);
        else                span = $urandom_range(0, 65535);
        return date_cmd($urandom_range(0, 1), yr, mon, dd, span);
    endfunction

    // hold start until the command beat is taken
    task automatic send_date(input t_cdo_in cmd, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= cmd;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        t_cdo_in directed[$];
        int      idle_pct[4];
        int      gap;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_in    <= '0;
        idle_pct = '{0, 62, 0, 20};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero offset, invalid dates, leap rules, wraps and saturation
        directed.push_back(date_cmd(CDO_MODE_ADD, 2024, 2, 29, 0));
        directed.push_back(date_cmd(CDO_MODE_SUB, 1999, 7, 14, 0));
        directed.push_back(date_cmd(CDO_MODE_ADD, 10000, 1, 1, 5));
        directed.push_back(date_cmd(CDO_MODE_SUB, 16383, 15, 31, 65535));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2000, 0, 10, 3));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2000, 13, 10, 3));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2000, 5, 0, 3));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2000, 4, 31, 3));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2023, 2, 29, 1));
        directed.push_back(date_cmd(CDO_MODE_ADD, 1900, 2, 29, 1));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2000, 2, 29, 1));
        directed.push_back(date_cmd(CDO_MODE_SUB, 0, 2, 29, 59));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2024, 2, 28, 1));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2100, 2, 28, 1));
        directed.push_back(date_cmd(CDO_MODE_SUB, 2023, 1, 1, 1));
        directed.push_back(date_cmd(CDO_MODE_ADD, 2023, 12, 31, 1));
        directed.push_back(date_cmd(CDO_MODE_SUB, 2024, 3, 1, 1));
        directed.push_back(date_cmd(CDO_MODE_ADD, 9999, 12, 31, 1));
        directed.push_back(date_cmd(CDO_MODE_ADD, 9990, 1, 1, 65535));
        directed.push_back(date_cmd(CDO_MODE_SUB, 0, 1, 1, 1));
        directed.push_back(date_cmd(CDO_MODE_SUB, 10, 6, 15, 65535));
        directed.push_back(date_cmd(CDO_MODE_ADD, 0, 1, 1, 65535));
        directed.push_back(date_cmd(CDO_MODE_SUB, 9999, 12, 31, 65535));
        foreach (directed[i])
            send_date(directed[i], 0);
        drain_results();

        // random phases with sender idle rates of 0, 62, 0 and 20 percent
        foreach (idle_pct[p]) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gap = ($urandom_range(0, 99) < idle_pct[p]) ? $urandom_range(1, 12) : 0;
                send_date(random_cmd(), gap);
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
